### sv/psm_pkg.sv
package psm_pkg;

  localparam int NUM_FRAMES_DEF        = 16;
  localparam int NUM_PROCESSES_DEF     = 4;
  localparam int PAGES_PER_PROCESS_DEF = 16;

  typedef enum logic [1:0] {
    OP_SWAP_OUT = 2'd0,
    OP_SWAP_IN  = 2'd1,
    OP_MAP      = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NO_FRAME  = 2'd2,
    ST_BAD_PLACE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

endpackage

### sv/psm_ram.sv
module psm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/page_swap_manager_unit.sv
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// request  | start_i / busy_o   | opcode_i process_id_i page_number_i frame_number_i
// result   | done_o (one cycle) | status_o source_index_o dest_index_o
//
// per item the page table is read in the accept cycle, then modified and
// written back in the next; the result strobe follows in the cycle after that,
// while a new item may already be accepted.
// after reset a clearing pass over all NUM_PROCESSES*PAGES_PER_PROCESS entries
// zeroes the page table; busy_o stays high meanwhile. the receiver cannot stall.
module page_swap_manager_unit #(
  parameter int NUM_FRAMES        = psm_pkg::NUM_FRAMES_DEF,
  parameter int NUM_PROCESSES     = psm_pkg::NUM_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = psm_pkg::PAGES_PER_PROCESS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] opcode_i,
  input  logic [1:0] process_id_i,
  input  logic [3:0] page_number_i,
  input  logic [3:0] frame_number_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [3:0] source_index_o,
  output logic [3:0] dest_index_o
);

  localparam int DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int EW    = FW + 2;

  psm_pkg::state_e  state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;

  psm_pkg::op_e     op_q;
  logic [3:0]       fr_q;
  logic [AW-1:0]    addr_q;
  logic             inrange_q;

  logic [NUM_FRAMES-1:0] frame_map_q, frame_map_d;
  logic [NUM_FRAMES-1:0] slot_map_q, slot_map_d;

  logic             done_q, done_d;
  psm_pkg::status_e status_q, status_d;
  logic [3:0]       src_q, src_d;
  logic [3:0]       dst_q, dst_d;

  logic             accept;
  logic [31:0]      addr_wide;
  logic             inrange;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    ram_rdata;

  logic             exec_we;
  logic [EW-1:0]    exec_wdata;

  logic             e_pres;
  logic             e_swap;
  logic [FW-1:0]    e_num;
  logic [FW-1:0]    frame_pick;
  logic [FW-1:0]    slot_pick;
  logic             fr_ok;
  logic [FW-1:0]    fr_idx;

  assign accept    = start_i && (state_q == psm_pkg::S_IDLE);
  assign addr_wide = 32'(process_id_i) * 32'(PAGES_PER_PROCESS) + 32'(page_number_i);
  assign inrange   = (32'(process_id_i) < 32'(NUM_PROCESSES)) &&
                     (32'(page_number_i) < 32'(PAGES_PER_PROCESS));

  psm_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(addr_wide[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      psm_pkg::S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = psm_pkg::S_IDLE;
        end
      end
      psm_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = psm_pkg::S_EXEC;
        end
      end
      psm_pkg::S_EXEC: begin
        state_d = psm_pkg::S_IDLE;
      end
      default: begin
        state_d = psm_pkg::S_IDLE;
      end
    endcase
  end

  // lowest free frame and slot
  always_comb begin
    frame_pick = '0;
    slot_pick  = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!frame_map_q[i]) begin
        frame_pick = FW'(i);
      end
      if (!slot_map_q[i]) begin
        slot_pick = FW'(i);
      end
    end
  end

  assign e_pres = ram_rdata[EW-1];
  assign e_swap = ram_rdata[EW-2];
  assign e_num  = ram_rdata[FW-1:0];
  assign fr_ok  = 32'(fr_q) < 32'(NUM_FRAMES);
  assign fr_idx = FW'(fr_q);

  // operation
  always_comb begin
    status_d    = psm_pkg::ST_BAD_PLACE;
    src_d       = '0;
    dst_d       = '0;
    exec_we     = 1'b0;
    exec_wdata  = '0;
    frame_map_d = frame_map_q;
    slot_map_d  = slot_map_q;
    if (inrange_q) begin
      unique case (op_q)
        psm_pkg::OP_SWAP_OUT: begin
          if (e_pres && !e_swap) begin
            if (&slot_map_q) begin
              status_d = psm_pkg::ST_NO_SLOT;
            end else begin
              slot_map_d[slot_pick] = 1'b1;
              frame_map_d[e_num]    = 1'b0;
              exec_we    = 1'b1;
              exec_wdata = {1'b0, 1'b1, slot_pick};
              status_d   = psm_pkg::ST_OK;
              src_d      = 4'(e_num);
              dst_d      = 4'(slot_pick);
            end
          end
        end
        psm_pkg::OP_SWAP_IN: begin
          if (e_swap && !e_pres) begin
            if (&frame_map_q) begin
              status_d = psm_pkg::ST_NO_FRAME;
            end else begin
              frame_map_d[frame_pick] = 1'b1;
              slot_map_d[e_num]       = 1'b0;
              exec_we    = 1'b1;
              exec_wdata = {1'b1, 1'b0, frame_pick};
              status_d   = psm_pkg::ST_OK;
              src_d      = 4'(e_num);
              dst_d      = 4'(frame_pick);
            end
          end
        end
        psm_pkg::OP_MAP: begin
          if (!e_pres && !e_swap) begin
            if (!fr_ok || frame_map_q[fr_idx]) begin
              status_d = psm_pkg::ST_NO_FRAME;
            end else begin
              frame_map_d[fr_idx] = 1'b1;
              exec_we    = 1'b1;
              exec_wdata = {1'b1, 1'b0, fr_idx};
              status_d   = psm_pkg::ST_OK;
              dst_d      = fr_q;
            end
          end
        end
        psm_pkg::OP_NONE: begin
          status_d = psm_pkg::ST_BAD_PLACE;
        end
        default: begin
          status_d = psm_pkg::ST_BAD_PLACE;
        end
      endcase
    end
  end

  // outputs and memory write port
  always_comb begin
    done_d    = (state_q == psm_pkg::S_EXEC);
    busy_o    = (state_q != psm_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = exec_wdata;
    unique case (state_q)
      psm_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      psm_pkg::S_EXEC: begin
        ram_we = exec_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psm_pkg::S_CLEAR;
      clr_cnt_q   <= '0;
      frame_map_q <= '0;
      slot_map_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
      if (state_q == psm_pkg::S_EXEC) begin
        frame_map_q <= frame_map_d;
        slot_map_q  <= slot_map_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= psm_pkg::op_e'(opcode_i);
      fr_q      <= frame_number_i;
      addr_q    <= addr_wide[AW-1:0];
      inrange_q <= inrange;
    end
    if (state_q == psm_pkg::S_EXEC) begin
      status_q <= status_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign source_index_o = src_q;
  assign dest_index_o   = dst_q;

endmodule

### sv/psm_checker.sv
module psm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] opcode_i,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [3:0] source_index_o,
  input logic [3:0] dest_index_o
);

  // every accepted item yields its result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("item without result");

  // no result without an earlier accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without item");

  // a failed item names no indexes
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != psm_pkg::ST_OK) |->
      (source_index_o == 4'd0) && (dest_index_o == 4'd0))
    else $error("failed item with indexes");

  // a mapped page has no source
  a_map_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == psm_pkg::ST_OK) && $past(opcode_i == psm_pkg::OP_MAP, 2) |->
      (source_index_o == 4'd0))
    else $error("map with source index");

endmodule

bind page_swap_manager_unit psm_checker u_psm_checker (.*);
